[hw/rtl/mvfs_pkg.sv]
// ----------------------------------------------------------------------------
// mvfs_pkg
// Shared widths, constants and types of the motion vector frame statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package mvfs_pkg;

  localparam int unsigned VEC_W         = 16;
  localparam int unsigned VEC_FRAC_BITS = 4;
  localparam int unsigned MAX_BLOCKS    = 65536;

  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned COUNT_W = 17;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned PCT_W   = 14;
  localparam int unsigned MUL_W   = 17;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(30);
  localparam logic [THRESH_W-1:0]   THRESH_RESET   = THRESH_W'((1 << VEC_FRAC_BITS) >> 1);
  localparam logic [MUL_W-1:0]      PCT_SCALE      = MUL_W'(10000);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = CFG_IDX_W'(1);

  // iterative unit: root and quotient steps, 1 quotient bit per step
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned STEP_CNT_W = 5;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] result;
  } iter_sts_t;

endpackage

`default_nettype wire

[hw/rtl/mvfs_if.sv]
// ----------------------------------------------------------------------------
// mvfs channel interfaces
// Valid/ready channels for vectors in, frame results out and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvfs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvfs_pkg::VEC_W-1:0]   vec_x;
  logic signed [mvfs_pkg::VEC_W-1:0]   vec_y;
  logic                                frame_end;

  modport source (output valid, output vec_x, output vec_y, output frame_end, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input frame_end, output ready);
endinterface

interface mvfs_out_if;
  logic                             valid;
  logic                             ready;
  logic [mvfs_pkg::PCT_W-1:0]       moving_percent;
  logic [mvfs_pkg::MAG_W-1:0]       mean_magnitude;
  logic [mvfs_pkg::MAG_W-1:0]       peak_magnitude;
  logic [mvfs_pkg::COUNT_W-1:0]     moving_blocks;
  logic [mvfs_pkg::COUNT_W-1:0]     block_total;
  logic                             overflowed;

  modport source (output valid, output moving_percent, output mean_magnitude,
                  output peak_magnitude, output moving_blocks, output block_total,
                  output overflowed, input ready);
  modport sink   (input valid, input moving_percent, input mean_magnitude,
                  input peak_magnitude, input moving_blocks, input block_total,
                  input overflowed, output ready);
endinterface

interface mvfs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mvfs_pkg::CFG_IDX_W-1:0]     index;
  logic [mvfs_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/motion_vector_frame_stats_top.sv]
// Flow: an unmeasured item or a dropped non-last item goes straight back to idle; a measured
//   item passes the accept cycle, the squaring of x and y, the root steps and the done cycle.
// Last item of a measured frame: then the share and mean divisions (the mean only if a block
//   moved; a dropped last block skips the root), plus any wait for the result register.
// Throughput: one item at a time, taken only in idle; in a measured frame set by the shared unit.
// Reset: synchronous, active low; registers return to defaults, statistics clear.
// ----------------------------------------------------------------------------
// motion_vector_frame_stats_top
// Per-frame motion statistics from block motion vectors, sampled frames only.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_vector_frame_stats_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mvfs_in_if.sink    in_ch,
  mvfs_out_if.source out_ch,
  mvfs_cfg_if.sink   cfg_ch
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQX    = 8'b0000_0010,
    S_SQY    = 8'b0000_0100,
    S_ROOT   = 8'b0000_1000,
    S_PCT    = 8'b0001_0000,
    S_PCT_W  = 8'b0010_0000,
    S_MEAN_W = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  localparam logic [mvfs_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  state_t state_r, state_nxt;

  logic [mvfs_pkg::INTERVAL_W-1:0] interval_r;
  logic [mvfs_pkg::THRESH_W-1:0]   thresh_r;

  logic [mvfs_pkg::INTERVAL_W-1:0] frame_count_r;
  logic                            mid_frame_r;
  logic                            measuring_r;
  logic [mvfs_pkg::COUNT_W-1:0]    total_r;
  logic [mvfs_pkg::COUNT_W-1:0]    moving_r;
  logic [mvfs_pkg::SUM_W-1:0]      mag_sum_r;
  logic [mvfs_pkg::MAG_W-1:0]      peak_r;
  logic                            ovf_r;
  logic                            last_r;
  logic [mvfs_pkg::VEC_W-1:0]      ax_r;
  logic [mvfs_pkg::VEC_W-1:0]      ay_r;
  logic [31:0]                     sq_r;
  logic [mvfs_pkg::PCT_W-1:0]      pct_r;
  logic [mvfs_pkg::MAG_W-1:0]      mean_r;

  logic                            out_valid_r;
  logic [mvfs_pkg::PCT_W-1:0]      out_pct_r;
  logic [mvfs_pkg::MAG_W-1:0]      out_mean_r;
  logic [mvfs_pkg::MAG_W-1:0]      out_peak_r;
  logic [mvfs_pkg::COUNT_W-1:0]    out_moving_r;
  logic [mvfs_pkg::COUNT_W-1:0]    out_total_r;
  logic                            out_ovf_r;

  // accept-time frame logic
  logic                            in_acc;
  logic                            frame_start;
  logic [mvfs_pkg::INTERVAL_W-1:0] fc_inc;
  logic                            meas_new;
  logic                            meas_now;
  logic [mvfs_pkg::COUNT_W-1:0]    total_eff;
  logic                            full;
  logic [mvfs_pkg::VEC_W-1:0]      abs_x;
  logic [mvfs_pkg::VEC_W-1:0]      abs_y;

  // shared multiplier and iterative unit
  logic [mvfs_pkg::MUL_W-1:0]      mul_a;
  logic [mvfs_pkg::MUL_W-1:0]      mul_b;
  logic [2*mvfs_pkg::MUL_W-1:0]    mul_p;
  mvfs_pkg::iter_cmd_t             it_cmd;
  mvfs_pkg::iter_sts_t             it_sts;
  logic [31:0]                     it_a;
  logic [mvfs_pkg::COUNT_W-1:0]    it_b;

  logic [mvfs_pkg::MAG_W-1:0]      mag;
  logic [mvfs_pkg::SUM_W:0]        sum_ext;
  logic                            out_free;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  always_comb begin
    frame_start = !mid_frame_r;
    fc_inc      = frame_count_r + 1'b1;
    meas_new    = (fc_inc >= interval_r);
    meas_now    = frame_start ? meas_new : measuring_r;
    total_eff   = frame_start ? '0 : total_r;
    full        = ({15'd0, total_eff} >= 32'(mvfs_pkg::MAX_BLOCKS));
    abs_x       = in_ch.vec_x[mvfs_pkg::VEC_W-1] ? (~in_ch.vec_x + 1'b1) : in_ch.vec_x;
    abs_y       = in_ch.vec_y[mvfs_pkg::VEC_W-1] ? (~in_ch.vec_y + 1'b1) : in_ch.vec_y;
    mag         = it_sts.result[mvfs_pkg::MAG_W-1:0];
    sum_ext     = {1'b0, mag_sum_r} + {{(mvfs_pkg::SUM_W+1-mvfs_pkg::MAG_W){1'b0}}, mag};
  end

  // operand selection for the multiplier and iterative unit, and next-state logic
  always_comb begin
    mul_a     = {1'b0, ax_r};
    mul_b     = {1'b0, ax_r};
    it_cmd    = '{start: 1'b0, op: mvfs_pkg::OP_SQRT};
    it_a      = sq_r + mul_p[31:0];
    it_b      = total_r;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!meas_now) begin
            state_nxt = S_IDLE;
          end else if (full) begin
            state_nxt = in_ch.frame_end ? S_PCT : S_IDLE;
          end else begin
            state_nxt = S_SQX;
          end
        end
      end
      S_SQX: begin
        state_nxt = S_SQY;
      end
      S_SQY: begin
        mul_a     = {1'b0, ay_r};
        mul_b     = {1'b0, ay_r};
        it_cmd    = '{start: 1'b1, op: mvfs_pkg::OP_SQRT};
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (it_sts.done) begin
          state_nxt = last_r ? S_PCT : S_IDLE;
        end
      end
      S_PCT: begin
        mul_a = moving_r;
        mul_b = mvfs_pkg::PCT_SCALE;
        it_a  = mul_p[31:0];
        if (total_r != '0) begin
          it_cmd    = '{start: 1'b1, op: mvfs_pkg::OP_DIV};
          state_nxt = S_PCT_W;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PCT_W: begin
        it_a = mag_sum_r;
        it_b = moving_r;
        if (it_sts.done) begin
          if (moving_r != '0) begin
            it_cmd    = '{start: 1'b1, op: mvfs_pkg::OP_DIV};
            state_nxt = S_MEAN_W;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MEAN_W: begin
        if (it_sts.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  mvfs_iter_unit u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (it_cmd),
    .opnd_a (it_a),
    .opnd_b (it_b),
    .sts    (it_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      interval_r    <= mvfs_pkg::INTERVAL_RESET;
      thresh_r      <= mvfs_pkg::THRESH_RESET;
      frame_count_r <= '0;
      mid_frame_r   <= 1'b0;
      measuring_r   <= 1'b0;
      total_r       <= '0;
      moving_r      <= '0;
      mag_sum_r     <= '0;
      peak_r        <= '0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          mvfs_pkg::REG_SAMPLE_INTERVAL:  interval_r <= cfg_ch.data[mvfs_pkg::INTERVAL_W-1:0];
          mvfs_pkg::REG_MOTION_THRESHOLD: thresh_r   <= cfg_ch.data[mvfs_pkg::THRESH_W-1:0];
          default: ;
        endcase
      end

      // a new result item in S_OUT takes the register over instead
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (frame_start) begin
              frame_count_r <= meas_new ? '0 : fc_inc;
              measuring_r   <= meas_new;
              total_r       <= '0;
              moving_r      <= '0;
              mag_sum_r     <= '0;
              peak_r        <= '0;
              ovf_r         <= 1'b0;
            end
            mid_frame_r <= !in_ch.frame_end;
            last_r      <= in_ch.frame_end;
            ax_r        <= abs_x;
            ay_r        <= abs_y;
            // a block past the limit is dropped but still flags the frame
            if (meas_now && full) begin
              ovf_r <= 1'b1;
            end
          end
        end
        S_SQX: begin
          sq_r <= mul_p[31:0];
        end
        S_ROOT: begin
          if (it_sts.done) begin
            if (total_r != COUNT_MAX) begin
              total_r <= total_r + 1'b1;
            end
            if (mag >= thresh_r) begin
              if (moving_r != COUNT_MAX) begin
                moving_r <= moving_r + 1'b1;
              end
              mag_sum_r <= sum_ext[mvfs_pkg::SUM_W] ? '1 : sum_ext[mvfs_pkg::SUM_W-1:0];
              if (mag > peak_r) begin
                peak_r <= mag;
              end
            end
          end
        end
        S_PCT: begin
          pct_r  <= '0;
          mean_r <= '0;
        end
        S_PCT_W: begin
          if (it_sts.done) begin
            pct_r <= it_sts.result[mvfs_pkg::PCT_W-1:0];
          end
        end
        S_MEAN_W: begin
          if (it_sts.done) begin
            mean_r <= it_sts.result[mvfs_pkg::MAG_W-1:0];
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_pct_r    <= pct_r;
            out_mean_r   <= mean_r;
            out_peak_r   <= peak_r;
            out_moving_r <= moving_r;
            out_total_r  <= total_r;
            out_ovf_r    <= ovf_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.moving_percent = out_pct_r;
  assign out_ch.mean_magnitude = out_mean_r;
  assign out_ch.peak_magnitude = out_peak_r;
  assign out_ch.moving_blocks  = out_moving_r;
  assign out_ch.block_total    = out_total_r;
  assign out_ch.overflowed     = out_ovf_r;

endmodule

`default_nettype wire

[hw/rtl/mvfs_iter_unit.sv]
// ----------------------------------------------------------------------------
// mvfs_iter_unit
// Shared shift/subtract unit: floor square root (16 steps) or unsigned
// division of a 32-bit dividend by a 17-bit divisor (32 steps).
// ----------------------------------------------------------------------------
`default_nettype none

module mvfs_iter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mvfs_pkg::iter_cmd_t           cmd,
  input  wire logic [31:0]                   opnd_a,
  input  wire logic [mvfs_pkg::COUNT_W-1:0]  opnd_b,
  output mvfs_pkg::iter_sts_t                sts
);

  logic                                busy_r;
  logic                                done_r;
  mvfs_pkg::iter_op_t                  op_r;
  logic [mvfs_pkg::STEP_CNT_W-1:0]     cnt_r;
  logic [31:0]                         acc_r;   // radicand rest / dividend-quotient
  logic [31:0]                         work_r;  // root / partial remainder
  logic [mvfs_pkg::COUNT_W-1:0]        dvs_r;

  logic [31:0] bit_v;
  logic [31:0] root_sum;
  logic [32:0] sub_a;
  logic [32:0] sub_b;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    bit_v    = 32'd1 << {cnt_r[3:0], 1'b0};
    root_sum = work_r + bit_v;
    if (op_r == mvfs_pkg::OP_SQRT) begin
      sub_a = {1'b0, acc_r};
      sub_b = {1'b0, root_sum};
    end else begin
      // remainder stays below the divisor, so 18 bits after the shift
      sub_a = {14'd0, work_r[17:0], acc_r[31]};
      sub_b = {16'd0, dvs_r};
    end
    diff = sub_a - sub_b;
    ge   = ~diff[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start && !busy_r) begin
        busy_r <= 1'b1;
        op_r   <= cmd.op;
        cnt_r  <= (cmd.op == mvfs_pkg::OP_SQRT) ?
                  mvfs_pkg::STEP_CNT_W'(mvfs_pkg::SQRT_STEPS - 1) :
                  mvfs_pkg::STEP_CNT_W'(mvfs_pkg::DIV_STEPS - 1);
        acc_r  <= opnd_a;
        work_r <= '0;
        dvs_r  <= opnd_b;
      end else if (busy_r) begin
        if (op_r == mvfs_pkg::OP_SQRT) begin
          if (ge) begin
            acc_r  <= diff[31:0];
            work_r <= (work_r >> 1) + bit_v;
          end else begin
            work_r <= work_r >> 1;
          end
        end else begin
          work_r <= ge ? {14'd0, diff[17:0]} : {14'd0, sub_a[17:0]};
          acc_r  <= {acc_r[30:0], ge};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts.busy   = busy_r;
    sts.done   = done_r;
    sts.result = (op_r == mvfs_pkg::OP_SQRT) ? work_r : acc_r;
  end

endmodule

`default_nettype wire

[hw/rtl/mvfs_checker.sv]
// ----------------------------------------------------------------------------
// mvfs_checker
// Port-level checks of the frame statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mvfs_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [mvfs_pkg::PCT_W-1:0]        moving_percent,
  input wire logic [mvfs_pkg::MAG_W-1:0]        mean_magnitude,
  input wire logic [mvfs_pkg::MAG_W-1:0]        peak_magnitude,
  input wire logic [mvfs_pkg::COUNT_W-1:0]      moving_blocks,
  input wire logic [mvfs_pkg::COUNT_W-1:0]      block_total
);

  // a waiting result item holds until taken (valid, share and block total checked)
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(moving_percent) && $stable(block_total))
    else $error("result item changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> moving_blocks <= block_total && moving_percent <= 14'd10000)
    else $error("moving count or share out of range");

  a_mean_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> mean_magnitude <= peak_magnitude)
    else $error("mean above peak");

  a_no_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && moving_blocks == '0 |-> peak_magnitude == '0 && mean_magnitude == '0)
    else $error("magnitudes set with no moving blocks");

endmodule

bind motion_vector_frame_stats_top mvfs_checker u_mvfs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .moving_percent (out_ch.moving_percent),
  .mean_magnitude (out_ch.mean_magnitude),
  .peak_magnitude (out_ch.peak_magnitude),
  .moving_blocks  (out_ch.moving_blocks),
  .block_total    (out_ch.block_total)
);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives block motion vectors and register writes into the frame statistics
// block, predicts each sampled frame's result and checks every field.
// ----------------------------------------------------------------------------
module tb;
  import mvfs_pkg::*;

  localparam int unsigned COUNT_MAX     = (1 << COUNT_W) - 1;
  localparam int unsigned CYCLE_LIMIT   = 8_000_000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int          PHASE_BLOCKS  = 90;
  localparam int          PHASES        = 10;

  typedef struct packed {
    logic [PCT_W-1:0]   pct;
    logic [MAG_W-1:0]   mean;
    logic [MAG_W-1:0]   peak;
    logic [COUNT_W-1:0] movers;
    logic [COUNT_W-1:0] blocks;
    logic               ovf;
  } frame_stats_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_BLOCK
  } row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    val;
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic                     last;
    int                       reps;
    bit                       typed;
    frame_stats_t             want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  mvfs_in_if  in_ch();
  mvfs_out_if out_ch();
  mvfs_cfg_if cfg_ch();

  motion_vector_frame_stats_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor copy of registers and frame state
  logic [INTERVAL_W-1:0] interval_reg;
  logic [THRESH_W-1:0]   threshold_reg;
  logic [INTERVAL_W-1:0] frame_tally;
  logic                  in_frame;
  logic                  sampling;
  logic [COUNT_W-1:0]    blocks_seen;
  logic [COUNT_W-1:0]    movers_seen;
  logic [SUM_W-1:0]      mag_sum;
  logic [MAG_W-1:0]      mag_peak;
  logic                  overflow_hit;

  frame_stats_t stats_due[$];
  plan_row_t    plan[$];
  int           errors;
  int unsigned  cycles;
  int           gap_max;
  int           stall_max;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, stats_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [MAG_W-1:0] floor_root(input logic [31:0] s);
    logic [MAG_W-1:0]  root;
    longint unsigned   trial;
    root = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = longint'(root) | (64'd1 << b);
      if (trial * trial <= longint'(s)) root = trial[MAG_W-1:0];
    end
    return root;
  endfunction

  task automatic predict_block(input logic signed [VEC_W-1:0] x, input logic signed [VEC_W-1:0] y,
                               input logic last, output bit emits, output frame_stats_t r);
    int              sx;
    int              sy;
    int unsigned     ax;
    int unsigned     ay;
    logic [MAG_W-1:0] mag;
    longint unsigned acc;
    emits = 1'b0;
    r = '0;
    if (!in_frame) begin
      frame_tally = frame_tally + 1'b1;
      sampling = (frame_tally >= interval_reg);
      if (sampling) frame_tally = '0;
      blocks_seen = '0;
      movers_seen = '0;
      mag_sum = '0;
      mag_peak = '0;
      overflow_hit = 1'b0;
    end
    in_frame = !last;
    if (sampling) begin
      if (blocks_seen >= MAX_BLOCKS) begin
        // frame full: block dropped, flag raised, frame_end still honoured
        overflow_hit = 1'b1;
      end else begin
        sx = x;
        sy = y;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        mag = floor_root(ax * ax + ay * ay);
        if (blocks_seen < COUNT_MAX) blocks_seen = blocks_seen + 1'b1;
        if (mag >= threshold_reg) begin
          if (movers_seen < COUNT_MAX) movers_seen = movers_seen + 1'b1;
          acc = longint'(mag_sum) + longint'(mag);
          mag_sum = (acc > 64'hFFFF_FFFF) ? '1 : acc[SUM_W-1:0];
          if (mag > mag_peak) mag_peak = mag;
        end
      end
      if (last) begin
        emits = 1'b1;
        if (blocks_seen != 0) begin
          acc = longint'(movers_seen) * 64'd10000 / longint'(blocks_seen);
          r.pct = acc[PCT_W-1:0];
        end
        if (movers_seen != 0) begin
          acc = longint'(mag_sum) / longint'(movers_seen);
          r.mean = acc[MAG_W-1:0];
        end
        r.peak   = mag_peak;
        r.movers = movers_seen;
        r.blocks = blocks_seen;
        r.ovf    = overflow_hit;
      end
    end
  endtask

  task automatic send_block(input logic signed [VEC_W-1:0] x, input logic signed [VEC_W-1:0] y,
                            input logic last, input bit typed, input frame_stats_t want);
    int           gap;
    bit           emits;
    frame_stats_t r;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.vec_x     <= x;
    in_ch.vec_y     <= y;
    in_ch.frame_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_block(x, y, last, emits, r);
    if (typed) stats_due.push_back(want);
    else if (emits) stats_due.push_back(r);
  endtask

  // waits until no result is due; the pause covers items still in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_SAMPLE_INTERVAL) interval_reg = val[INTERVAL_W-1:0];
    else if (idx == REG_MOTION_THRESHOLD) threshold_reg = val[THRESH_W-1:0];
  endtask

  function automatic logic signed [VEC_W-1:0] pick_component();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3: return VEC_W'($urandom);
      default: return VEC_W'($urandom_range(0, 160) - 80);
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int k = 1; k <= len; k++) send_block(pick_component(), pick_component(), k == len, 1'b0, '0);
  endtask

  function automatic plan_row_t blk(input logic signed [VEC_W-1:0] x,
                                    input logic signed [VEC_W-1:0] y,
                                    input logic last, input int reps);
    plan_row_t row;
    row.kind  = ROW_BLOCK;
    row.idx   = '0;
    row.val   = '0;
    row.vx    = x;
    row.vy    = y;
    row.last  = last;
    row.reps  = reps;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic plan_row_t blk_chk(input logic signed [VEC_W-1:0] x,
                                        input logic signed [VEC_W-1:0] y,
                                        input logic last, input frame_stats_t want);
    plan_row_t row;
    row = blk(x, y, last, 1);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = blk(16'sd0, 16'sd0, 1'b0, 0);
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : score
    frame_stats_t head;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (stats_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pct %0d blocks %0d",
                 $time, out_ch.moving_percent, out_ch.block_total);
        errors++;
      end else begin
        head = stats_due.pop_front();
        check_field("moving_percent", head.pct,    out_ch.moving_percent);
        check_field("mean_magnitude", head.mean,   out_ch.mean_magnitude);
        check_field("peak_magnitude", head.peak,   out_ch.peak_magnitude);
        check_field("moving_blocks",  head.movers, out_ch.moving_blocks);
        check_field("block_total",    head.blocks, out_ch.block_total);
        check_field("overflowed",     head.ovf,    out_ch.overflowed);
      end
    end
  end

  // result side: random stall before taking each item
  initial begin : drain
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : main
    int                    sent;
    int                    len;
    logic [CFG_DATA_W-1:0] thr;
    cycles = 0;
    errors = 0;
    gap_max = 14;
    stall_max = 14;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.vec_x     <= '0;
    in_ch.vec_y     <= '0;
    in_ch.frame_end <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    interval_reg  = INTERVAL_RESET;
    threshold_reg = THRESH_RESET;
    frame_tally   = '0;
    in_frame      = 1'b0;
    sampling      = 1'b0;
    blocks_seen   = '0;
    movers_seen   = '0;
    mag_sum       = '0;
    mag_peak      = '0;
    overflow_hit  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: 29 skipped frames, the 30th measured at half a pixel
    plan.push_back(blk(16'sd0, 16'sd0, 1'b1, 29));
    plan.push_back(blk(16'sd7, 16'sd0, 1'b0, 1));
    plan.push_back(blk_chk(16'sd0, -16'sd8, 1'b1, frame_stats_t'{5000, 8, 8, 1, 2, 0}));
    plan.push_back(reg_row(REG_SAMPLE_INTERVAL, 16'd1));
    plan.push_back(blk_chk(16'sh8000, 16'sh8000, 1'b1,
                           frame_stats_t'{10000, 46340, 46340, 1, 1, 0}));
    plan.push_back(blk_chk(16'sh7FFF, 16'sh7FFF, 1'b1,
                           frame_stats_t'{10000, 46339, 46339, 1, 1, 0}));
    plan.push_back(blk(16'sh8000, 16'sh7FFF, 1'b1, 1));
    plan.push_back(blk_chk(16'sd3, 16'sd4, 1'b1, frame_stats_t'{0, 0, 0, 0, 1, 0}));
    plan.push_back(reg_row(REG_MOTION_THRESHOLD, 16'd0));
    plan.push_back(blk_chk(16'sd0, 16'sd0, 1'b1, frame_stats_t'{10000, 0, 0, 1, 1, 0}));
    plan.push_back(reg_row(REG_MOTION_THRESHOLD, 16'hFFFF));
    plan.push_back(blk(16'sh8000, 16'sh8000, 1'b0, 1));
    plan.push_back(blk_chk(16'sh7FFF, -16'sd1, 1'b1, frame_stats_t'{0, 0, 0, 0, 2, 0}));
    plan.push_back(reg_row(REG_MOTION_THRESHOLD, 16'd5));
    plan.push_back(blk(16'sd3, 16'sd4, 1'b0, 1));
    plan.push_back(blk(16'sd6, -16'sd8, 1'b0, 1));
    plan.push_back(blk_chk(16'sd1, 16'sd1, 1'b1, frame_stats_t'{6666, 7, 10, 2, 3, 0}));
    // zero interval samples every frame
    plan.push_back(reg_row(REG_SAMPLE_INTERVAL, 16'd0));
    plan.push_back(blk_chk(-16'sd5, 16'sd0, 1'b1, frame_stats_t'{10000, 5, 5, 1, 1, 0}));
    plan.push_back(blk(16'sd0, 16'sd5, 1'b0, 1));
    plan.push_back(blk_chk(16'sh8000, 16'sd0, 1'b1,
                           frame_stats_t'{10000, 16386, 32768, 2, 2, 0}));
    plan.push_back(reg_row(REG_SAMPLE_INTERVAL, 16'd3));
    plan.push_back(blk(16'sd1, 16'sd2, 1'b1, 3));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        repeat (plan[i].reps)
          send_block(plan[i].vx, plan[i].vy, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      gap_max   = (ph % 4 == 3) ? 0 : 14;
      stall_max = (ph % 3 == 2) ? 0 : 14;
      case (ph % 5)
        0: write_reg(REG_SAMPLE_INTERVAL, 16'd1);
        1: write_reg(REG_SAMPLE_INTERVAL, CFG_DATA_W'($urandom_range(2, 4)));
        2: write_reg(REG_SAMPLE_INTERVAL, 16'd0);
        3: write_reg(REG_SAMPLE_INTERVAL, 16'd1);
        default: write_reg(REG_SAMPLE_INTERVAL, CFG_DATA_W'($urandom_range(5, 12)));
      endcase
      case ($urandom_range(0, 5))
        0: thr = '0;
        1: thr = '1;
        2: thr = CFG_DATA_W'($urandom_range(0, 65535));
        default: thr = CFG_DATA_W'($urandom_range(0, 128));
      endcase
      write_reg(REG_MOTION_THRESHOLD, thr);
      sent = 0;
      while (sent < PHASE_BLOCKS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        send_frame(len);
        sent += len;
      end
    end

    // widest interval: enough one-block frames to reach a sample
    gap_max = 0;
    stall_max = 14;
    write_reg(REG_SAMPLE_INTERVAL, 16'd1023);
    write_reg(REG_MOTION_THRESHOLD, CFG_DATA_W'($urandom_range(0, 64)));
    repeat (1030) send_block(pick_component(), pick_component(), 1'b1, 1'b0, '0);

    in_ch.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mvfs_pkg.sv
hw/rtl/mvfs_if.sv
hw/rtl/mvfs_iter_unit.sv
hw/rtl/motion_vector_frame_stats_top.sv
hw/rtl/mvfs_checker.sv
bench/tb.sv
